// ===== rtl/p1305_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Poly1305 package
// Shared types and codes for the Poly1305 authenticator.
// ----------------------------------------------------------------------------
package p1305_pkg;

	localparam int unsigned LimbW = 26;
	localparam int unsigned NumLimbs = 5;

	typedef logic [LimbW-1:0] limb_t;
	typedef logic [129:0] acc_t;

	typedef enum logic [1:0] {
		REG_R_LOW  = 2'd0,
		REG_R_HIGH = 2'd1,
		REG_S_LOW  = 2'd2,
		REG_S_HIGH = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FOLD,
		ST_FINAL,
		ST_TAG
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/p1305_mac_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Poly1305 multiply-accumulate unit
// One 28x29 bit multiplier; sums five partial products into one column per
// step under control of the sequencer.
// ----------------------------------------------------------------------------
module p1305_mac_unit
	import p1305_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        clear,
	input  wire logic        en,
	input  wire logic [27:0] a,
	input  wire logic [28:0] b,
	output logic      [63:0] sum
);

	logic [56:0] prod;
	logic [63:0] sum_q;

	assign prod = {29'd0, a} * {28'd0, b};
	assign sum  = sum_q;

	always_ff @(posedge clk) begin
		if (clear) begin
			sum_q <= 64'd0;
		end else if (en) begin
			sum_q <= sum_q + {7'd0, prod};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/poly1305_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Poly1305 one-time authenticator over one shared 28x29 multiplier.
// Each block runs through accept, 5 columns of 5 products plus a carry step,
// fold and final reduce; the tag is then formed, straight from accept if the last block is empty.
// A new block is taken only once the previous one is done; input waits while a tag is held.
// Reset clears the key registers, the accumulator and all handshake state.
// ----------------------------------------------------------------------------
module poly1305_mac
	import p1305_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [135:0] s_tdata,  // block_low, block_high, byte_count, pad
	input  wire logic         s_tlast,  // last
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [127:0] m_tdata   // tag_low, tag_high
);

	logic [63:0] r_low_q, r_high_q, s_low_q, s_high_q;
	acc_t acc_q;
	logic [130:0] h_q;
	logic last_q;
	state_t state_q, state_d;
	logic [2:0] col_q, term_q;
	logic [127:0] tag_q;
	logic [63:0] carry_q;
	limb_t d_q [NumLimbs];

	logic [129:0] rc;
	limb_t r_l [NumLimbs];
	logic [27:0] h_l [NumLimbs];
	assign rc = {2'b00, r_high_q & 64'h0ffffffc0ffffffc, r_low_q & 64'h0ffffffc0fffffff};
	always_comb begin
		for (int i = 0; i < NumLimbs; i++) begin
			r_l[i] = rc[i*26 +: 26];
			h_l[i] = (i == 4) ? {1'b0, h_q[130:104]} : {2'b00, h_q[i*26 +: 26]};
		end
	end

	// column col: sum over term j of h[j]*r[col-j] (or 5*r[col-j+5])
	logic [2:0] ri;
	logic wrap;
	logic [28:0] bop;
	always_comb begin
		wrap = term_q > col_q;
		ri = wrap ? 3'(col_q + 3'd5 - term_q) : 3'(col_q - term_q);
		bop = wrap ? {3'd0, r_l[ri]} * 29'd5 : {3'd0, r_l[ri]};
	end

	logic mac_clear, mac_en;
	logic [63:0] col_sum;
	p1305_mac_unit u_mac (
		.clk(clk), .clear(mac_clear), .en(mac_en),
		.a(h_l[term_q]), .b(bop), .sum(col_sum)
	);

	// block pad and mask
	logic [4:0] cnt;
	logic [127:0] mask;
	logic [130:0] blk;
	always_comb begin
		cnt = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
		mask = (cnt == 5'd16) ? '1 : ((128'd1 << {cnt, 3'b000}) - 128'd1);
		blk = {3'd0, s_tdata[127:0] & mask} | (131'd1 << {cnt, 3'b000});
	end

	logic accept;
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign m_tdata = tag_q;

	logic [63:0] csum;
	assign csum = col_sum + carry_q;

	// fold the top carry back in, then subtract p if needed
	logic [130:0] hn, fold;
	logic [131:0] g;
	always_comb begin
		hn = '0;
		for (int i = 0; i < NumLimbs; i++) hn[i*26 +: 26] = d_q[i];
		fold = {1'b0, hn[129:0]} + 131'(carry_q) * 131'd5;
		g = {1'b0, acc_q} + 132'd5;
	end

	always_comb begin
		state_d = state_q;
		mac_clear = 1'b0;
		mac_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mac_clear = 1'b1;
				if (accept) begin
					if (cnt != 5'd0) state_d = ST_MUL;
					else if (s_tlast) state_d = ST_TAG;
				end
			end
			ST_MUL: begin
				mac_en = (term_q != 3'd5);
				mac_clear = (term_q == 3'd5);
				if (term_q == 3'd5 && col_q == 3'd4) state_d = ST_FOLD;
			end
			ST_FOLD: state_d = ST_FINAL;
			ST_FINAL: state_d = last_q ? ST_TAG : ST_IDLE;
			ST_TAG: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_low_q <= '0; r_high_q <= '0; s_low_q <= '0; s_high_q <= '0;
			acc_q <= '0;
			m_tvalid <= 1'b0;
			col_q <= '0; term_q <= '0; carry_q <= '0; last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_R_LOW:  r_low_q <= cfg_data;
					REG_R_HIGH: r_high_q <= cfg_data;
					REG_S_LOW:  s_low_q <= cfg_data;
					REG_S_HIGH: s_high_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						h_q <= {1'b0, acc_q} + ((cnt == 5'd0) ? 131'd0 : blk);
						last_q <= s_tlast;
						col_q <= '0; term_q <= '0; carry_q <= '0;
					end
				end
				ST_MUL: begin
					if (term_q == 3'd5) begin
						// close column: keep 26 bits, carry the rest
						d_q[col_q] <= csum[25:0];
						carry_q <= {26'd0, csum[63:26]};
						term_q <= '0;
						col_q <= col_q + 3'd1;
					end else begin
						term_q <= term_q + 3'd1;
					end
				end
				ST_FOLD: acc_q <= fold[129:0] + 130'(fold[130]) * 130'd5;
				ST_FINAL: if (g[130]) acc_q <= g[129:0];
				ST_TAG: begin
					tag_q <= acc_q[127:0] + {s_high_q, s_low_q};
					m_tvalid <= 1'b1;
					acc_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire
